/* rtl/core/trsa_pkg.sv */
`timescale 1ns / 1ps

package trsa_pkg;

    localparam int NUM_SLOTS_DEF = 10;
    localparam int TIME_W        = 32;
    localparam int SLOT_IDX_W    = 4;
    localparam int IN_DATA_W     = 2 * TIME_W;
    localparam int OUT_DATA_W    = 8;

endpackage

/* rtl/core/timed_release_slot_allocator.sv */
`timescale 1ns / 1ps

// Timed-release slot allocator.
// The input stream carries one request per beat: a start time and an end time,
// both unsigned microsecond counts. For every request the block first frees each
// busy slot whose stored release time is not later than the start time, then
// grants the lowest-numbered free slot and stores the end time as its release time.
// The output stream returns one beat per request: the granted slot number in
// tdata and an exhausted flag in tuser, set when no slot was free (slot number 0).
// An accepted request goes into the input register, then through the compare and
// lowest-free search into the result register. One request is taken every cycle
// while the receiver takes results; the slot state is updated in the same cycle
// the result is registered, so back-to-back requests see each other's grants.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more request; tready drops only when both are full.
// A synchronous active-low reset frees all slots and empties both registers;
// stored release times are not cleared, since a slot's time is always written
// before the slot becomes busy.

module timed_release_slot_allocator #(
    parameter int NUM_SLOTS = trsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [trsa_pkg::IN_DATA_W-1:0]   i_s_tdata,   // start_time, end_time
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [trsa_pkg::OUT_DATA_W-1:0]  o_m_tdata,   // slot_index, zero fill
    output logic [0:0]                       o_m_tuser    // exhausted
);

    import trsa_pkg::*;

    logic                  r_in_valid;
    logic [TIME_W-1:0]     r_start;
    logic [TIME_W-1:0]     r_end;
    logic                  r_out_valid;
    logic [SLOT_IDX_W-1:0] r_out_idx;
    logic                  r_out_exh;
    logic [NUM_SLOTS-1:0]  r_busy;
    logic [TIME_W-1:0]     r_rel_time [NUM_SLOTS];

    logic                  in_take;
    logic                  advance;
    logic [NUM_SLOTS-1:0]  n_busy_rel;
    logic [NUM_SLOTS-1:0]  free_mask;
    logic [NUM_SLOTS-1:0]  grant_mask;
    logic                  any_free;
    logic [SLOT_IDX_W-1:0] grant_idx;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_busy_rel[i] = r_busy[i] && (r_rel_time[i] > r_start);
        end
        free_mask  = ~n_busy_rel;
        grant_mask = free_mask & (~free_mask + NUM_SLOTS'(1));
        any_free   = |free_mask;
        grant_idx  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (grant_mask[i]) begin
                grant_idx = grant_idx | SLOT_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_busy      <= n_busy_rel | grant_mask;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_start <= i_s_tdata[TIME_W-1:0];
            r_end   <= i_s_tdata[2*TIME_W-1:TIME_W];
        end
        if (advance) begin
            r_out_idx <= grant_idx;
            r_out_exh <= !any_free;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (grant_mask[i]) begin
                    r_rel_time[i] <= r_end;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - SLOT_IDX_W)'(0), r_out_idx};
    assign o_m_tuser  = r_out_exh;

endmodule

/* rtl/core/trsa_checker.sv */
`timescale 1ns / 1ps

module trsa_checker #(
    parameter int NUM_SLOTS = trsa_pkg::NUM_SLOTS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [trsa_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic [0:0]                       o_m_tuser
);

    import trsa_pkg::*;

    // The block must not produce a result right after reset.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // An exhausted result reports slot zero.
    a_exh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[SLOT_IDX_W-1:0] == '0))
        else $error("exhausted result with nonzero slot");

    // A granted slot lies within the slot range.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0] && (NUM_SLOTS <= 16))
            |-> (int'(o_m_tdata[SLOT_IDX_W-1:0]) < NUM_SLOTS))
        else $error("granted slot out of range");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready)
            |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind timed_release_slot_allocator trsa_checker #(.NUM_SLOTS(NUM_SLOTS)) u_trsa_checker (.*);
